>>> sv/swm_pkg.sv
// Shared types and constants for the sliding window minimum block.
package swm_pkg;

    localparam int SAMPLE_W = 32;
    localparam int WLEN_W   = 4;

    localparam logic [WLEN_W-1:0] WLEN_RESET = 4'd3;

    // One stored sample of the shift line and whether it is still a candidate.
    typedef struct packed {
        logic                       live;
        logic signed [SAMPLE_W-1:0] value;
    } swm_cell_t;

endpackage

>>> sv/swm_cell.sv
// One cell of the sample chain: holds a sample and its candidate flag.
module swm_cell
    import swm_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       shift_en,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic                       in_window,
    input  swm_cell_t                  prev,
    output swm_cell_t                  cur
);

    logic                       live_reg;
    logic                       live_next;
    logic signed [SAMPLE_W-1:0] value_reg;
    logic signed [SAMPLE_W-1:0] value_next;

    // Drop the candidate once a smaller sample arrives or it ages out.
    always_comb
    begin
        live_next  = prev.live && !(prev.value > sample) && in_window;
        value_next = prev.value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= 1'b0;
        end
        else if (shift_en)
        begin
            live_reg <= live_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            value_reg <= value_next;
        end
    end

    assign cur.live  = live_reg;
    assign cur.value = value_reg;

endmodule

>>> sv/swm_front_select.sv
// Picks the oldest live cell of the chain, which holds the window minimum.
module swm_front_select
    import swm_pkg::*;
#(
    parameter int DEPTH = 8
)
(
    input  swm_cell_t                  cells [DEPTH],
    output logic signed [SAMPLE_W-1:0] front
);

    logic [DEPTH-1:0] older_live;
    logic [DEPTH-1:0] pick;

    always_comb
    begin
        older_live[DEPTH-1] = 1'b0;
        for (int i = DEPTH - 2; i >= 0; i--)
        begin
            older_live[i] = older_live[i+1] | cells[i+1].live;
        end
        for (int i = 0; i < DEPTH; i++)
        begin
            pick[i] = cells[i].live & ~older_live[i];
        end
    end

    always_comb
    begin
        front = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            front = front | (cells[i].value & {SAMPLE_W{pick[i]}});
        end
    end

endmodule

>>> sv/sliding_window_minimum.sv
// Top level of the sliding window minimum: cell chain, front select, output stage.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------
//  in      | in        | in_valid / in_stall | sample (32 bit signed)
//  out     | out       | out_valid/out_stall | window_min (32 bit signed)
//  cfg     | in        | cfg_we              | cfg_data (window_length, 4 bit)
//
//  An item is accepted every cycle while the output side keeps up; each item
//  passes through the chain update, then through the front select into the
//  output register. The front select over WINDOW_MAX cells sets the path
//  from the chain to the output register.
//  Reset clears every candidate flag, empties both stages and sets the
//  window length to 3. A stalled output holds its item; the input is then
//  stalled only once the item behind it also has nowhere to go.
module sliding_window_minimum
    import swm_pkg::*;
#(
    parameter int WINDOW_MAX = 8
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [SAMPLE_W-1:0] sample,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [SAMPLE_W-1:0] window_min,
    input  logic                       cfg_we,
    input  logic [WLEN_W-1:0]          cfg_data
);

    // Width wide enough to compare a cell position against the window length.
    localparam int LEN_W = $clog2(WINDOW_MAX + 1);
    localparam int CMP_W = (LEN_W > WLEN_W) ? LEN_W : WLEN_W;

    logic [WLEN_W-1:0]          window_length_reg;
    logic [WLEN_W-1:0]          wlen_eff;
    logic                       chain_valid_reg;
    logic                       chain_valid_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic signed [SAMPLE_W-1:0] window_min_reg;
    logic signed [SAMPLE_W-1:0] front;
    logic                       in_accept;
    logic                       chain_move;
    logic [WINDOW_MAX-1:0]      in_window;
    swm_cell_t                  head;
    swm_cell_t                  cell_q [WINDOW_MAX];

    // Window length register; zero acts as one, the chain length caps it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= WLEN_RESET;
        end
        else if (cfg_we)
        begin
            window_length_reg <= cfg_data;
        end
    end

    assign wlen_eff = (window_length_reg == '0) ? WLEN_W'(1) : window_length_reg;

    // Handshake: the chain result moves on when the output register is free
    // or is being emptied; a new item enters when the chain is empty or its result moves.
    assign chain_move = chain_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall   = chain_valid_reg && !chain_move;
    assign in_accept  = in_valid && !in_stall;

    // The new sample enters cell 0 as a live candidate.
    assign head.live  = 1'b1;
    assign head.value = sample;

    // Cell i holds the sample that arrived i items ago; it stays a candidate
    // only while it lies inside the window.
    for (genvar i = 0; i < WINDOW_MAX; i++)
    begin : g_cell
        assign in_window[i] = CMP_W'(i) < CMP_W'(wlen_eff);

        if (i == 0)
        begin : g_first
            swm_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .shift_en  (in_accept),
                .sample    (sample),
                .in_window (in_window[i]),
                .prev      (head),
                .cur       (cell_q[i])
            );
        end
        else
        begin : g_rest
            swm_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .shift_en  (in_accept),
                .sample    (sample),
                .in_window (in_window[i]),
                .prev      (cell_q[i-1]),
                .cur       (cell_q[i])
            );
        end
    end

    // Live candidates grow older towards the end of the chain and never
    // rise in value, so the oldest live one is the minimum.
    swm_front_select #(
        .DEPTH (WINDOW_MAX)
    ) u_front (
        .cells (cell_q),
        .front (front)
    );

    always_comb
    begin
        chain_valid_next = chain_valid_reg;
        if (in_accept)
        begin
            chain_valid_next = 1'b1;
        end
        else if (chain_move)
        begin
            chain_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (chain_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            chain_valid_reg <= chain_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Hold the result while the output is stalled.
    always_ff @(posedge clk)
    begin
        if (chain_move)
        begin
            window_min_reg <= front;
        end
    end

    assign out_valid  = out_valid_reg;
    assign window_min = window_min_reg;

    // After an item enters, the newest cell is always a candidate.
    a_head_live: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (chain_valid_reg && cell_q[0].live))
        else $error("newest cell not live after an accepted item");

    // A waiting chain result always has a live front.
    a_front_exists: assert property (@(posedge clk) disable iff (!rst_n)
        chain_valid_reg |-> cell_q[0].live)
        else $error("chain result pending with no live candidate");

    // A result leaving the chain lands in the output register.
    a_move_lands: assert property (@(posedge clk) disable iff (!rst_n)
        chain_move |=> out_valid_reg)
        else $error("chain result lost on its way to the output");

    // With both stages full and the output stalled, no item may enter.
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (chain_valid_reg && out_valid_reg && out_stall) |-> !in_accept)
        else $error("item accepted while both stages are full");

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the sliding window minimum block.
`timescale 1ns / 100ps

module testbench
    import swm_pkg::*;
();

    localparam int WMAX        = 8;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 12;

    // One row of the directed part: optional window write, sample and,
    // where it is plain to see, the minimum that must come back.
    typedef struct packed {
        logic                       set_win;
        logic [WLEN_W-1:0]          win;
        logic signed [SAMPLE_W-1:0] smp;
        logic                       known;
        logic signed [SAMPLE_W-1:0] want;
    } stim_row_t;

    localparam int DIR_ROWS = 24;

    stim_row_t dir_rows [DIR_ROWS] = '{
        // window 3 from reset: the first sample is its own minimum
        '{1'b0, 4'd0,  32'sh7FFFFFFF, 1'b1, 32'sh7FFFFFFF},
        '{1'b0, 4'd0,  32'sh80000000, 1'b1, 32'sh80000000},
        '{1'b0, 4'd0,  32'sd0,        1'b1, 32'sh80000000},
        '{1'b0, 4'd0, -32'sd1,        1'b0, 32'sd0},
        '{1'b0, 4'd0,  32'sd5,        1'b0, 32'sd0},
        // equal values: the older copy stays queued
        '{1'b0, 4'd0,  32'sd5,        1'b0, 32'sd0},
        '{1'b0, 4'd0,  32'sd3,        1'b0, 32'sd0},
        // zero window behaves as one: each result is its own sample
        '{1'b1, 4'd0,  32'sd42,       1'b1, 32'sd42},
        '{1'b0, 4'd0, -32'sd7,        1'b1, -32'sd7},
        '{1'b0, 4'd0,  32'sd100,      1'b1, 32'sd100},
        // window above the maximum saturates; a rising ramp fills the queue
        '{1'b1, 4'd15, 32'sd1,        1'b0, 32'sd0},
        '{1'b0, 4'd0,  32'sd2,        1'b0, 32'sd0},
        '{1'b0, 4'd0,  32'sd3,        1'b0, 32'sd0},
        '{1'b0, 4'd0,  32'sd4,        1'b0, 32'sd0},
        '{1'b0, 4'd0,  32'sd5,        1'b0, 32'sd0},
        '{1'b0, 4'd0,  32'sd6,        1'b0, 32'sd0},
        '{1'b0, 4'd0,  32'sd7,        1'b0, 32'sd0},
        '{1'b0, 4'd0,  32'sd8,        1'b0, 32'sd0},
        '{1'b0, 4'd0,  32'sd9,        1'b0, 32'sd0},
        // shrink the window with a full queue: several front entries go at once
        '{1'b1, 4'd2,  32'sd100,      1'b0, 32'sd0},
        '{1'b0, 4'd0,  32'sd50,       1'b0, 32'sd0},
        '{1'b1, 4'd1, -32'sd5,        1'b1, -32'sd5},
        '{1'b1, 4'd8,  32'shAAAAAAAA, 1'b0, 32'sd0},
        '{1'b0, 4'd0,  32'sh55555555, 1'b0, 32'sd0}
    };

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       out_valid;
    logic                       out_stall;
    logic signed [SAMPLE_W-1:0] window_min;
    logic                       cfg_we;
    logic [WLEN_W-1:0]          cfg_data;

    // Predictor state: monotonic queue of candidates, oldest at the front.
    logic signed [SAMPLE_W-1:0] cand_val [WMAX];
    int                         cand_age [WMAX];
    int                         cand_cnt;
    logic [WLEN_W-1:0]          win_len;

    // Minima still owed by the block, oldest first.
    logic signed [SAMPLE_W-1:0] min_q [$];

    int  errors;
    int  checked;
    int  sent;
    int  settings;
    int  cycle_cnt;
    int  stall_left;
    int  ramp_val;
    int  ramp_step;
    bit  calm;
    bit  hold_req;

    sliding_window_minimum #(.WINDOW_MAX(WMAX)) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample     (sample),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .window_min (window_min),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Drop the oldest candidate and close the gap.
    function automatic void drop_oldest_cand();
        for (int k = 0; k + 1 < cand_cnt; k++)
        begin
            cand_val[k] = cand_val[k + 1];
            cand_age[k] = cand_age[k + 1];
        end
        if (cand_cnt > 0)
            cand_cnt--;
    endfunction

    // Advance the candidate queue by one sample and return the window minimum.
    function automatic logic signed [SAMPLE_W-1:0] predict_min(
        input logic signed [SAMPLE_W-1:0] s
    );
        int span;
        span = int'(win_len);
        if (span > WMAX)
            span = WMAX;
        if (span == 0)
            span = 1;
        // age every candidate, saturating where it is certainly out of range
        for (int k = 0; k < cand_cnt; k++)
            if (cand_age[k] < WMAX)
                cand_age[k]++;
        // drop every front entry that has left the window, not just one
        while (cand_cnt > 0 && cand_age[0] >= span)
            drop_oldest_cand();
        // strictly greater tail entries can never be the minimum again
        while (cand_cnt > 0 && cand_val[cand_cnt - 1] > s)
            cand_cnt--;
        if (cand_cnt >= WMAX)
            drop_oldest_cand();
        cand_val[cand_cnt] = s;
        cand_age[cand_cnt] = 0;
        cand_cnt++;
        return cand_val[0];
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Random sample: wide values, a narrow band for ties, ramps and extremes.
    function automatic logic signed [SAMPLE_W-1:0] next_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return $urandom;
        if (r < 65)
            return int'($urandom_range(0, 16)) - 8;
        if (r < 90)
        begin
            if ($urandom_range(0, 9) == 0)
                ramp_step = int'($urandom_range(0, 6)) - 3;
            ramp_val += ramp_step;
            return ramp_val;
        end
        case ($urandom_range(0, 3))
            0:       return 32'sh7FFFFFFF;
            1:       return 32'sh80000000;
            2:       return 32'sd0;
            default: return -32'sd1;
        endcase
    endfunction

    // Offer one sample after a random gap; hold it until taken, then
    // queue the minimum it must produce.
    task automatic send_sample(
        input logic signed [SAMPLE_W-1:0] s,
        input logic                       known,
        input logic signed [SAMPLE_W-1:0] want
    );
        int                         gap;
        logic signed [SAMPLE_W-1:0] pred;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        sample   <= s;
        do
            @(posedge clk);
        while (in_stall);
        pred  = predict_min(s);
        min_q = {min_q, (known ? want : pred)};
        sent++;
    endtask

    // Write the window length once the block has drained.
    task automatic set_window(input logic [WLEN_W-1:0] w);
        @(negedge clk);
        in_valid <= 1'b0;
        while (min_q.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= w;
        @(negedge clk);
        cfg_we   <= 1'b0;
        win_len  = w;
        settings++;
    endtask

    // Receiver: random stalls of varied length, plus one long hold-off on
    // request so the block backs up into its input.
    initial
    begin
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else if (!calm && $urandom_range(0, 99) < 20)
            begin
                stall_left = pick_gap();
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Compare each delivered minimum with the oldest one owed.
    always @(posedge clk)
    begin
        logic signed [SAMPLE_W-1:0] owed;
        if (rst_n && out_valid && !out_stall)
        begin
            if (min_q.size() == 0)
            begin
                $error("window_min: unexpected item, got %0d", window_min);
                errors++;
            end
            else
            begin
                owed = min_q[0];
                min_q.delete(0);
                if (window_min !== owed)
                begin
                    $error("window_min mismatch: expected %0d, actual %0d",
                           owed, window_min);
                    errors++;
                end
                checked++;
            end
        end
    end

    // Guard against a hung handshake.
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d minima still owed",
                     cycle_cnt, min_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        int wl;
        int n;
        in_valid  = 1'b0;
        sample    = '0;
        out_stall = 1'b0;
        cfg_we    = 1'b0;
        cfg_data  = '0;
        rst_n     = 1'b0;
        errors    = 0;
        checked   = 0;
        sent      = 0;
        settings  = 0;
        cycle_cnt = 0;
        ramp_val  = 0;
        ramp_step = 1;
        calm      = 1'b0;
        hold_req  = 1'b0;
        cand_cnt  = 0;
        win_len   = WLEN_RESET;

        // hold reset, then release it away from the active edge
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed rows: extremes, ties, zero and oversize windows, shrink
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (dir_rows[i].set_win)
                set_window(dir_rows[i].win);
            send_sample(dir_rows[i].smp, dir_rows[i].known, dir_rows[i].want);
        end

        // random phases: extremes of the window first, then any setting
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       wl = 1;
                1:       wl = WMAX;
                2:       wl = 0;
                3:       wl = 15;
                default: wl = $urandom_range(0, 15);
            endcase
            set_window(wl[WLEN_W-1:0]);
            calm = (ph == 4) || ($urandom_range(0, 4) == 0);
            if (ph == 6)
            begin
                @(posedge clk);
                hold_req = 1'b1;
            end
            n = $urandom_range(60, 90);
            for (int i = 0; i < n; i++)
                send_sample(next_sample(), 1'b0, '0);
        end

        // drain, then allow the pipeline latency for any stray item
        @(negedge clk);
        in_valid <= 1'b0;
        calm = 1'b0;
        while (min_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Run covered %0d samples and %0d minima over %0d window writes",
                 sent, checked, settings);
        $display("including windows 0, 1, %0d and 15 and a %0d-cycle output hold-off",
                 WMAX, HOLD_CYCLES);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
